### sv/opcode_decode_effective_address_defines.svh
// Assertion macros used by the opcode decoder sequencer.
`ifndef OPCODE_DECODE_EFFECTIVE_ADDRESS_DEFINES_SVH
`define OPCODE_DECODE_EFFECTIVE_ADDRESS_DEFINES_SVH
// Property that must hold at every clock edge outside reset.
`define ODEA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property that must hold at every edge, reset included.
`define ODEA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### sv/odea_pkg.sv
// Package with the decode tables, addressing mode codes and helper functions.
`default_nettype none
package odea_pkg;
   localparam int ADDR_BITS_DEFAULT = 16;

   localparam logic [3:0] MODE_IMP = 4'd0;
   localparam logic [3:0] MODE_IMM = 4'd1;
   localparam logic [3:0] MODE_ZP  = 4'd2;
   localparam logic [3:0] MODE_ZPX = 4'd3;
   localparam logic [3:0] MODE_ZPY = 4'd4;
   localparam logic [3:0] MODE_ABS = 4'd5;
   localparam logic [3:0] MODE_ABX = 4'd6;
   localparam logic [3:0] MODE_ABY = 4'd7;
   localparam logic [3:0] MODE_IND = 4'd8;
   localparam logic [3:0] MODE_IZX = 4'd9;
   localparam logic [3:0] MODE_IZY = 4'd10;
   localparam logic [3:0] MODE_REL = 4'd11;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   localparam logic [7:0] OPC_JSR = 8'h20;
   localparam logic [7:0] OPC_JMP = 8'h4C;
   localparam logic [7:0] FLAG_N = 8'h80;
   localparam logic [7:0] FLAG_V = 8'h40;
   localparam logic [7:0] FLAG_Z = 8'h02;
   localparam logic [7:0] FLAG_C = 8'h01;

   localparam logic [5:0] MN_TAB [256] = '{
      1, 2, 0, 0,  0, 2, 3, 0,  4, 2, 3, 0,  0, 2, 3, 0,
      5, 2, 0, 0,  0, 2, 3, 0,  6, 2, 0, 0,  0, 2, 3, 0,
      7, 8, 0, 0,  9, 8,10, 0, 11, 8,10, 0,  9, 8,10, 0,
      12, 8, 0, 0,  0, 8,10, 0, 13, 8, 0, 0,  0, 8,10, 0,
      14,15, 0, 0,  0,15,16, 0, 17,15,16, 0, 18,15,16, 0,
      19,15, 0, 0,  0,15,16, 0, 20,15, 0, 0,  0,15,16, 0,
      21,22, 0, 0,  0,22,23, 0, 24,22,23, 0, 18,22,23, 0,
      25,22, 0, 0,  0,22,23, 0, 26,22, 0, 0,  0,22,23, 0,
      0,27, 0, 0, 28,27,29, 0, 30, 0,31, 0, 28,27,29, 0,
      32,27, 0, 0, 28,27,29, 0, 33,27,34, 0,  0,27, 0, 0,
      35,36,37, 0, 35,36,37, 0, 38,36,39, 0, 35,36,37, 0,
      40,36, 0, 0, 35,36,37, 0, 41,36,42, 0, 35,36,37, 0,
      43,44, 0, 0, 43,44,45, 0, 46,44,47, 0, 43,44,45, 0,
      48,44, 0, 0,  0,44,45, 0, 49,44, 0, 0,  0,44,45, 0,
      50,51, 0, 0, 50,51,52, 0, 53,51,54, 0, 50,51,52, 0,
      55,51, 0, 0,  0,51,52, 0, 56,51, 0, 0,  0,51,52, 0
   };

   localparam logic [3:0] MODE_TAB [256] = '{
      0, 9, 0, 9,  2, 2, 2, 2,  0, 1, 0, 1,  5, 5, 5, 5,
      11,10, 0,10,  3, 3, 3, 3,  0, 7, 0, 7,  6, 6, 6, 6,
      5, 9, 0, 9,  2, 2, 2, 2,  0, 1, 0, 1,  5, 5, 5, 5,
      11,10, 0,10,  3, 3, 3, 3,  0, 7, 0, 7,  6, 6, 6, 6,
      0, 9, 0, 9,  2, 2, 2, 2,  0, 1, 0, 1,  5, 5, 5, 5,
      11,10, 0,10,  3, 3, 3, 3,  0, 7, 0, 7,  6, 6, 6, 6,
      0, 9, 0, 9,  2, 2, 2, 2,  0, 1, 0, 1,  8, 5, 5, 5,
      11,10, 0,10,  3, 3, 3, 3,  0, 7, 0, 7,  6, 6, 6, 6,
      1, 9, 1, 9,  2, 2, 2, 2,  0, 1, 0, 1,  5, 5, 5, 5,
      11,10, 0,10,  3, 3, 4, 4,  0, 7, 0, 7,  6, 6, 7, 7,
      1, 9, 1, 9,  2, 2, 2, 2,  0, 1, 0, 1,  5, 5, 5, 5,
      11,10, 0,10,  3, 3, 4, 4,  0, 7, 0, 7,  6, 6, 7, 7,
      1, 9, 1, 9,  2, 2, 2, 2,  0, 1, 0, 1,  5, 5, 5, 5,
      11,10, 0,10,  3, 3, 3, 3,  0, 7, 0, 7,  6, 6, 6, 6,
      1, 9, 1, 9,  2, 2, 2, 2,  0, 1, 0, 1,  5, 5, 5, 5,
      11,10, 0,10,  3, 3, 3, 3,  0, 7, 0, 7,  6, 6, 6, 6
   };

   // Memory port request from the sequencer to the byte memory.
   typedef struct packed {
      logic        rd_en;
      logic        wr_en;
      logic [15:0] addr;
      logic [7:0]  wdata;
   } mem_req_type;

   function automatic logic [1:0] mode_length(input logic [3:0] mode);
      logic [1:0] len;
      case (mode)
         MODE_IMP: len = 2'd1;
         MODE_ABS, MODE_ABX, MODE_ABY, MODE_IND: len = 2'd3;
         default: len = 2'd2;
      endcase
      return len;
   endfunction

   function automatic logic branch_cond(input logic [7:0] opc, input logic [7:0] f);
      logic c;
      case (opc)
         8'h10: c = (f & FLAG_N) == 8'd0;
         8'h30: c = (f & FLAG_N) != 8'd0;
         8'h50: c = (f & FLAG_V) == 8'd0;
         8'h70: c = (f & FLAG_V) != 8'd0;
         8'h90: c = (f & FLAG_C) == 8'd0;
         8'hB0: c = (f & FLAG_C) != 8'd0;
         8'hD0: c = (f & FLAG_Z) == 8'd0;
         8'hF0: c = (f & FLAG_Z) != 8'd0;
         default: c = 1'b0;
      endcase
      return c;
   endfunction
endpackage
`default_nettype wire

### sv/opcode_decode_effective_address.sv
// Top level of the opcode decoder with effective-address evaluation.
//
// Input channel: an item is taken at a clock edge with start high and busy
// low. req_op low writes req_data into the byte memory at req_addr; req_op
// high decodes the instruction at req_addr and evaluates its addressing.
// Result channel: rsp_valid is high for exactly one cycle per item, with all
// rsp_ fields valid in that cycle. The receiver cannot hold results off.
// A decode makes its single-port memory reads one at a time (opcode, two
// operand bytes, up to two pointer bytes, and one data byte when the item
// has data); busy stays high until the result strobe, so one item is in
// flight at a time.
// Reset clears the sequencer to idle and drops the strobe; memory contents
// are kept and must be written before they are decoded.
`default_nettype none
module opcode_decode_effective_address #(
   parameter int ADDR_BITS = odea_pkg::ADDR_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_op,
   input  wire logic [15:0] req_addr,
   input  wire logic [7:0]  req_data,
   input  wire logic [7:0]  req_index_x,
   input  wire logic [7:0]  req_index_y,
   input  wire logic [7:0]  req_flags,
   input  wire logic        req_eval_branch,
   output logic             rsp_valid,
   output logic [7:0]       rsp_opcode,
   output logic [5:0]       rsp_mnemonic,
   output logic [3:0]       rsp_addr_mode,
   output logic [1:0]       rsp_instr_length,
   output logic [15:0]      rsp_operand_address,
   output logic [15:0]      rsp_effective_address,
   output logic [7:0]       rsp_data_value,
   output logic             rsp_has_data,
   output logic             rsp_branch_taken,
   output logic             rsp_branch_backward
);
   odea_pkg::mem_req_type mem_req;
   logic [7:0] mem_rdata;

   odea_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (
      .clock(clock), .req(mem_req), .rdata(mem_rdata)
   );

   odea_seq #(.ADDR_BITS(ADDR_BITS)) u_seq (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_addr(req_addr), .req_data(req_data),
      .req_index_x(req_index_x), .req_index_y(req_index_y),
      .req_flags(req_flags), .req_eval_branch(req_eval_branch),
      .mem_req(mem_req), .mem_rdata(mem_rdata),
      .rsp_valid(rsp_valid), .rsp_opcode(rsp_opcode),
      .rsp_mnemonic(rsp_mnemonic), .rsp_addr_mode(rsp_addr_mode),
      .rsp_instr_length(rsp_instr_length),
      .rsp_operand_address(rsp_operand_address),
      .rsp_effective_address(rsp_effective_address),
      .rsp_data_value(rsp_data_value), .rsp_has_data(rsp_has_data),
      .rsp_branch_taken(rsp_branch_taken),
      .rsp_branch_backward(rsp_branch_backward)
   );
endmodule
`default_nettype wire

### sv/odea_mem.sv
// Single-port byte memory with a registered read port.
`default_nettype none
module odea_mem #(
   parameter int ADDR_BITS = odea_pkg::ADDR_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire odea_pkg::mem_req_type req,
   output logic [7:0]                 rdata
);
   logic [7:0] mem [2**ADDR_BITS];
   logic [ADDR_BITS-1:0] idx;

   assign idx = req.addr[ADDR_BITS-1:0];

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[idx] <= req.wdata;
      end
      if (req.rd_en) begin
         rdata <= mem[idx];
      end
   end
endmodule
`default_nettype wire

### sv/odea_seq.sv
// Decode sequencer: issues the memory reads of one item and builds its result.
`default_nettype none
`include "opcode_decode_effective_address_defines.svh"
module odea_seq #(
   parameter int ADDR_BITS = odea_pkg::ADDR_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_op,
   input  wire logic [15:0]            req_addr,
   input  wire logic [7:0]             req_data,
   input  wire logic [7:0]             req_index_x,
   input  wire logic [7:0]             req_index_y,
   input  wire logic [7:0]             req_flags,
   input  wire logic                   req_eval_branch,
   output odea_pkg::mem_req_type       mem_req,
   input  wire logic [7:0]             mem_rdata,
   output logic                        rsp_valid,
   output logic [7:0]                  rsp_opcode,
   output logic [5:0]                  rsp_mnemonic,
   output logic [3:0]                  rsp_addr_mode,
   output logic [1:0]                  rsp_instr_length,
   output logic [15:0]                 rsp_operand_address,
   output logic [15:0]                 rsp_effective_address,
   output logic [7:0]                  rsp_data_value,
   output logic                        rsp_has_data,
   output logic                        rsp_branch_taken,
   output logic                        rsp_branch_backward
);
   localparam logic [15:0] AMASK = 16'((32'd1 << ADDR_BITS) - 32'd1);

   // Each read state issues one read; the byte arrives in the next state.
   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_OPC   = 9'b000000010,
      ST_LO    = 9'b000000100,
      ST_HI    = 9'b000001000,
      ST_PLO   = 9'b000010000,
      ST_PHI   = 9'b000100000,
      ST_DATA  = 9'b001000000,
      ST_DONE  = 9'b010000000,
      ST_WRITE = 9'b100000000
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] pc_ff, pc_in;
   logic [7:0]  x_ff, x_in, y_ff, y_in, f_ff, f_in;
   logic        ev_ff, ev_in;
   logic [7:0]  opc_ff, opc_in, lo_ff, lo_in, plo_ff, plo_in;
   logic [15:0] word_ff, word_in;
   logic [15:0] ea_ff, ea_in;
   logic [7:0]  dv_ff, dv_in;
   logic        has_ff, has_in;
   logic [3:0]  mode;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] oper, rel_target;
   logic [7:0]  zp_ptr;

   assign mode = odea_pkg::MODE_TAB[opc_ff];
   assign rel_target = (pc_ff + 16'd2 + {{8{lo_ff[7]}}, lo_ff}) & AMASK;
   assign zp_ptr = (mode == odea_pkg::MODE_IZX) ? 8'(lo_ff + x_ff) : lo_ff;

   always_comb begin
      case (mode)
         odea_pkg::MODE_IMP: oper = 16'd0;
         odea_pkg::MODE_ABS, odea_pkg::MODE_ABX, odea_pkg::MODE_ABY,
         odea_pkg::MODE_IND: oper = word_ff;
         odea_pkg::MODE_REL: oper = rel_target;
         default: oper = {8'd0, lo_ff};
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff; x_in = x_ff; y_in = y_ff; f_in = f_ff; ev_in = ev_ff;
      opc_in = opc_ff; lo_in = lo_ff; plo_in = plo_ff; word_in = word_ff;
      ea_in = ea_ff; dv_in = dv_ff; has_in = has_ff;
      rsp_valid_in = 1'b0;
      mem_req = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               pc_in = req_addr & AMASK;
               x_in = req_index_x; y_in = req_index_y;
               f_in = req_flags; ev_in = req_eval_branch;
               if (req_op == odea_pkg::OP_WRITE) begin
                  mem_req.wr_en = 1'b1;
                  mem_req.addr = req_addr & AMASK;
                  mem_req.wdata = req_data;
                  state_in = ST_WRITE;
               end else begin
                  mem_req.rd_en = 1'b1;
                  mem_req.addr = req_addr & AMASK;
                  state_in = ST_OPC;
               end
            end
         end
         ST_OPC: begin
            opc_in = mem_rdata;
            mem_req.rd_en = 1'b1;
            mem_req.addr = (pc_ff + 16'd1) & AMASK;
            state_in = ST_LO;
         end
         ST_LO: begin
            lo_in = mem_rdata;
            mem_req.rd_en = 1'b1;
            mem_req.addr = (pc_ff + 16'd2) & AMASK;
            state_in = ST_HI;
         end
         ST_HI: begin
            word_in = {mem_rdata, lo_ff} & AMASK;
            has_in = 1'b0;
            ea_in = 16'd0;
            state_in = ST_DONE;
            case (mode)
               odea_pkg::MODE_ZP: begin ea_in = {8'd0, lo_ff}; has_in = 1'b1; end
               odea_pkg::MODE_ZPX: begin
                  ea_in = {8'd0, 8'(lo_ff + x_ff)}; has_in = 1'b1;
               end
               odea_pkg::MODE_ZPY: begin
                  ea_in = {8'd0, 8'(lo_ff + y_ff)}; has_in = 1'b1;
               end
               odea_pkg::MODE_ABS: begin
                  ea_in = word_in;
                  has_in = (opc_ff != odea_pkg::OPC_JSR) && (opc_ff != odea_pkg::OPC_JMP);
               end
               odea_pkg::MODE_ABX: begin
                  ea_in = (word_in + {8'd0, x_ff}) & AMASK; has_in = 1'b1;
               end
               odea_pkg::MODE_ABY: begin
                  ea_in = (word_in + {8'd0, y_ff}) & AMASK; has_in = 1'b1;
               end
               odea_pkg::MODE_IND: begin
                  mem_req.rd_en = 1'b1; mem_req.addr = word_in;
                  state_in = ST_PLO;
               end
               odea_pkg::MODE_IZX, odea_pkg::MODE_IZY: begin
                  mem_req.rd_en = 1'b1; mem_req.addr = {8'd0, zp_ptr} & AMASK;
                  has_in = 1'b1;
                  state_in = ST_PLO;
               end
               default: begin end
            endcase
            if (has_in && state_in == ST_DONE) begin
               mem_req.rd_en = 1'b1; mem_req.addr = ea_in;
               state_in = ST_DATA;
            end
         end
         ST_PLO: begin
            plo_in = mem_rdata;
            mem_req.rd_en = 1'b1;
            if (mode == odea_pkg::MODE_IND) begin
               mem_req.addr = (word_ff + 16'd1) & AMASK;
            end else begin
               mem_req.addr = {8'd0, 8'(zp_ptr + 8'd1)} & AMASK;
            end
            state_in = ST_PHI;
         end
         ST_PHI: begin
            if (mode == odea_pkg::MODE_IZY) begin
               ea_in = ({mem_rdata, plo_ff} + {8'd0, y_ff}) & AMASK;
            end else begin
               ea_in = {mem_rdata, plo_ff} & AMASK;
            end
            if (has_ff) begin
               mem_req.rd_en = 1'b1; mem_req.addr = ea_in;
               state_in = ST_DATA;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DATA: begin
            dv_in = mem_rdata;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!has_ff) dv_in = 8'd0;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_WRITE: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pc_ff <= pc_in; x_ff <= x_in; y_ff <= y_in; f_ff <= f_in; ev_ff <= ev_in;
      opc_ff <= opc_in; lo_ff <= lo_in; plo_ff <= plo_in; word_ff <= word_in;
      ea_ff <= ea_in; dv_ff <= dv_in; has_ff <= has_in;
   end

   // Result registers are loaded when the item completes.
   logic [7:0]  r_opc_ff;
   logic [5:0]  r_mn_ff;
   logic [3:0]  r_mode_ff;
   logic [1:0]  r_len_ff;
   logic [15:0] r_oper_ff, r_ea_ff;
   logic [7:0]  r_dv_ff;
   logic        r_has_ff, r_taken_ff, r_back_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         r_opc_ff <= 8'd0; r_mn_ff <= 6'd0; r_mode_ff <= 4'd0; r_len_ff <= 2'd1;
         r_oper_ff <= 16'd0; r_ea_ff <= 16'd0; r_dv_ff <= 8'd0;
         r_has_ff <= 1'b0; r_taken_ff <= 1'b0; r_back_ff <= 1'b0;
      end else if (state_ff == ST_DONE) begin
         r_opc_ff <= opc_ff;
         r_mn_ff <= odea_pkg::MN_TAB[opc_ff];
         r_mode_ff <= mode;
         r_len_ff <= odea_pkg::mode_length(mode);
         r_oper_ff <= oper;
         r_ea_ff <= ea_ff;
         r_dv_ff <= has_ff ? dv_ff : 8'd0;
         r_has_ff <= has_ff;
         r_taken_ff <= (mode == odea_pkg::MODE_REL) && ev_ff &&
                       odea_pkg::branch_cond(opc_ff, f_ff);
         r_back_ff <= (mode == odea_pkg::MODE_REL) && (rel_target <= pc_ff);
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_opcode = r_opc_ff;
   assign rsp_mnemonic = r_mn_ff;
   assign rsp_addr_mode = r_mode_ff;
   assign rsp_instr_length = r_len_ff;
   assign rsp_operand_address = r_oper_ff;
   assign rsp_effective_address = r_ea_ff;
   assign rsp_data_value = r_dv_ff;
   assign rsp_has_data = r_has_ff;
   assign rsp_branch_taken = r_taken_ff;
   assign rsp_branch_backward = r_back_ff;

   `ODEA_ASSERT(a_one_result, clock, reset, rsp_valid |=> !rsp_valid, "result strobe repeated")
   `ODEA_ASSERT(a_done_strobe, clock, reset, (state_ff == ST_DONE || state_ff == ST_WRITE) |=> rsp_valid, "completed item gave no result")
   `ODEA_ASSERT(a_no_mem_write_busy, clock, reset, mem_req.wr_en |-> !busy, "memory written while busy")
   `ODEA_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !busy, "not idle after reset")
endmodule
`default_nettype wire

### tb/opcode_decode_effective_address_tb.sv
// Testbench for the opcode decoder: directed and random write and decode beats against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module opcode_decode_effective_address_tb;

   typedef struct packed {
      logic [7:0]  opcode;
      logic [5:0]  mnemonic;
      logic [3:0]  addr_mode;
      logic [1:0]  instr_length;
      logic [15:0] operand_address;
      logic [15:0] effective_address;
      logic [7:0]  data_value;
      logic        has_data;
      logic        branch_taken;
      logic        branch_backward;
   } decode_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_op = odea_pkg::OP_WRITE;
   logic [15:0] req_addr = '0;
   logic [7:0]  req_data = '0;
   logic [7:0]  req_index_x = '0;
   logic [7:0]  req_index_y = '0;
   logic [7:0]  req_flags = '0;
   logic        req_eval_branch = 1'b0;
   logic        rsp_valid;
   logic [7:0]  rsp_opcode;
   logic [5:0]  rsp_mnemonic;
   logic [3:0]  rsp_addr_mode;
   logic [1:0]  rsp_instr_length;
   logic [15:0] rsp_operand_address;
   logic [15:0] rsp_effective_address;
   logic [7:0]  rsp_data_value;
   logic        rsp_has_data;
   logic        rsp_branch_taken;
   logic        rsp_branch_backward;

   logic [7:0]        byte_mem [0:65535];
   bit                written [0:65535];
   decode_result_type pending_results [$];
   int                mismatches = 0;
   int                beats_sent = 0;
   int                writes_checked = 0;
   int                decodes_checked = 0;
   int                burst_left = 0;
   bit                mode_seen [0:15];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   opcode_decode_effective_address i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_op                (req_op),
      .req_addr              (req_addr),
      .req_data              (req_data),
      .req_index_x           (req_index_x),
      .req_index_y           (req_index_y),
      .req_flags             (req_flags),
      .req_eval_branch       (req_eval_branch),
      .rsp_valid             (rsp_valid),
      .rsp_opcode            (rsp_opcode),
      .rsp_mnemonic          (rsp_mnemonic),
      .rsp_addr_mode         (rsp_addr_mode),
      .rsp_instr_length      (rsp_instr_length),
      .rsp_operand_address   (rsp_operand_address),
      .rsp_effective_address (rsp_effective_address),
      .rsp_data_value        (rsp_data_value),
      .rsp_has_data          (rsp_has_data),
      .rsp_branch_taken      (rsp_branch_taken),
      .rsp_branch_backward   (rsp_branch_backward)
   );

   // Works out the result of a decode from the memory image held here.
   function automatic decode_result_type decode_predict(input logic op, input logic [15:0] pc,
         input logic [7:0] x, input logic [7:0] y, input logic [7:0] f, input logic ev);
      decode_result_type r;
      logic [7:0]  opc, lo, hi, zp;
      logic [15:0] word;
      logic        flag_bit;
      r = '0;
      r.instr_length = 2'd1;
      if (op == odea_pkg::OP_WRITE) begin
         return r;
      end
      opc = byte_mem[pc];
      lo = byte_mem[pc + 16'd1];
      hi = byte_mem[pc + 16'd2];
      word = {hi, lo};
      r.opcode = opc;
      r.mnemonic = odea_pkg::MN_TAB[opc];
      r.addr_mode = odea_pkg::MODE_TAB[opc];
      r.instr_length = 2'd2;
      case (r.addr_mode)
         odea_pkg::MODE_IMP: r.instr_length = 2'd1;
         odea_pkg::MODE_IMM: r.operand_address = {8'h00, lo};
         odea_pkg::MODE_ZP: begin
            r.operand_address = {8'h00, lo};
            r.effective_address = {8'h00, lo};
            r.has_data = 1'b1;
         end
         odea_pkg::MODE_ZPX, odea_pkg::MODE_ZPY: begin
            zp = lo + ((r.addr_mode == odea_pkg::MODE_ZPX) ? x : y);
            r.operand_address = {8'h00, lo};
            r.effective_address = {8'h00, zp};
            r.has_data = 1'b1;
         end
         odea_pkg::MODE_ABS: begin
            r.instr_length = 2'd3;
            r.operand_address = word;
            r.effective_address = word;
            r.has_data = (opc != odea_pkg::OPC_JSR) && (opc != odea_pkg::OPC_JMP);
         end
         odea_pkg::MODE_ABX, odea_pkg::MODE_ABY: begin
            r.instr_length = 2'd3;
            r.operand_address = word;
            r.effective_address = word +
                                  {8'h00, (r.addr_mode == odea_pkg::MODE_ABX) ? x : y};
            r.has_data = 1'b1;
         end
         odea_pkg::MODE_IND: begin
            // The pointer's second byte carries into the high byte of the pointer.
            r.instr_length = 2'd3;
            r.operand_address = word;
            r.effective_address = {byte_mem[word + 16'd1], byte_mem[word]};
         end
         odea_pkg::MODE_IZX: begin
            zp = lo + x;
            r.operand_address = {8'h00, lo};
            r.effective_address = {byte_mem[{8'h00, zp + 8'd1}], byte_mem[{8'h00, zp}]};
            r.has_data = 1'b1;
         end
         odea_pkg::MODE_IZY: begin
            r.operand_address = {8'h00, lo};
            r.effective_address = {byte_mem[{8'h00, lo + 8'd1}], byte_mem[{8'h00, lo}]}
                                  + {8'h00, y};
            r.has_data = 1'b1;
         end
         default: begin
            // Branches: the top two opcode bits pick N, V, C or Z; bit 5 is the value wanted.
            r.operand_address = pc + 16'd2 + {{8{lo[7]}}, lo};
            r.branch_backward = r.operand_address <= pc;
            case (opc[7:6])
               2'd0: flag_bit = (f & odea_pkg::FLAG_N) != 8'd0;
               2'd1: flag_bit = (f & odea_pkg::FLAG_V) != 8'd0;
               2'd2: flag_bit = (f & odea_pkg::FLAG_C) != 8'd0;
               default: flag_bit = (f & odea_pkg::FLAG_Z) != 8'd0;
            endcase
            r.branch_taken = ev && (flag_bit == opc[5]);
         end
      endcase
      if (r.has_data) begin
         r.data_value = byte_mem[r.effective_address];
      end
      return r;
   endfunction

   // Drives one beat from a falling edge and returns at the falling edge after it is taken.
   task automatic send_beat(input logic op, input logic [15:0] addr, input logic [7:0] data,
         input logic [7:0] x, input logic [7:0] y, input logic [7:0] f, input logic ev);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      start = 1'b1;
      req_op = op;
      req_addr = addr;
      req_data = data;
      req_index_x = x;
      req_index_y = y;
      req_flags = f;
      req_eval_branch = ev;
      do @(posedge clock); while (busy);
      pending_results.push_back(decode_predict(op, addr, x, y, f, ev));
      if (op == odea_pkg::OP_WRITE) begin
         byte_mem[addr] = data;
         written[addr] = 1'b1;
      end
      beats_sent++;
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic write_byte(input logic [15:0] addr, input logic [7:0] data);
      send_beat(odea_pkg::OP_WRITE, addr, data, $urandom, $urandom, $urandom, $urandom);
   endtask

   // Fills a byte the decode will read, unless it already holds something.
   task automatic fill_if_empty(input logic [15:0] addr);
      if (!written[addr]) begin
         write_byte(addr, $urandom);
      end
   endtask

   // Places an instruction (or keeps the bytes already there) and decodes it, having first
   // written every pointer and data byte the decode will touch.
   task automatic decode_at(input logic [15:0] pc, input bit keep, input logic [7:0] opc,
         input logic [7:0] lo, input logic [7:0] hi, input logic [7:0] x, input logic [7:0] y,
         input logic [7:0] f, input logic ev);
      decode_result_type r;
      logic [3:0] mode;
      logic [7:0] zp;
      logic [15:0] word;
      if (keep) begin
         fill_if_empty(pc);
         fill_if_empty(pc + 16'd1);
         fill_if_empty(pc + 16'd2);
      end else begin
         write_byte(pc, opc);
         write_byte(pc + 16'd1, lo);
         write_byte(pc + 16'd2, hi);
      end
      mode = odea_pkg::MODE_TAB[byte_mem[pc]];
      zp = byte_mem[pc + 16'd1];
      word = {byte_mem[pc + 16'd2], zp};
      case (mode)
         odea_pkg::MODE_IND: begin
            fill_if_empty(word);
            fill_if_empty(word + 16'd1);
         end
         odea_pkg::MODE_IZX: begin
            fill_if_empty({8'h00, zp + x});
            fill_if_empty({8'h00, zp + x + 8'd1});
         end
         odea_pkg::MODE_IZY: begin
            fill_if_empty({8'h00, zp});
            fill_if_empty({8'h00, zp + 8'd1});
         end
         default: ;
      endcase
      r = decode_predict(odea_pkg::OP_DECODE, pc, x, y, f, ev);
      if (r.has_data) begin
         fill_if_empty(r.effective_address);
      end
      send_beat(odea_pkg::OP_DECODE, pc, $urandom, x, y, f, ev);
   endtask

   task automatic wait_for_results();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   always @(posedge clock) begin
      decode_result_type want, got;
      if (!reset && rsp_valid) begin
         got = '{rsp_opcode, rsp_mnemonic, rsp_addr_mode, rsp_instr_length,
                 rsp_operand_address, rsp_effective_address, rsp_data_value,
                 rsp_has_data, rsp_branch_taken, rsp_branch_backward};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result beat: %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("Mismatch:\n  expected %p\n  actual   %p", want, got);
            end
            if (want.instr_length == 2'd1 && want.opcode == 8'd0
                && want.addr_mode == odea_pkg::MODE_IMP && want.mnemonic == 6'd0) begin
               writes_checked++;
            end else begin
               decodes_checked++;
            end
            mode_seen[want.addr_mode] = 1'b1;
         end
      end
   end

   task automatic test_addressing_modes();
      // Branch forward, branch backward with the largest offsets, and one evaluated for each flag.
      decode_at(16'h0200, 1'b0, 8'h10, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
      decode_at(16'h0300, 1'b0, 8'h30, 8'h80, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1);
      decode_at(16'h0310, 1'b0, 8'h50, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
      decode_at(16'h0320, 1'b0, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 1'b1);
      decode_at(16'h0330, 1'b0, 8'h90, 8'h05, 8'h00, 8'h00, 8'h00, 8'hFE, 1'b1);
      decode_at(16'h0340, 1'b0, 8'hB0, 8'h05, 8'h00, 8'h00, 8'h00, 8'h01, 1'b0);
      decode_at(16'h0350, 1'b0, 8'hD0, 8'h05, 8'h00, 8'h00, 8'h00, 8'h02, 1'b1);
      decode_at(16'h0360, 1'b0, 8'hF0, 8'h05, 8'h00, 8'h00, 8'h00, 8'h02, 1'b1);
      // The instruction bytes wrap past the top of memory.
      decode_at(16'hFFFF, 1'b0, 8'hAD, 8'h34, 8'h12, 8'h00, 8'h00, 8'h00, 1'b1);
      decode_at(16'h0400, 1'b0, 8'hA9, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      decode_at(16'h0410, 1'b0, 8'hB5, 8'hF0, 8'h00, 8'h20, 8'h00, 8'h00, 1'b0);
      decode_at(16'h0420, 1'b0, 8'hB6, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0);
      decode_at(16'h0430, 1'b0, 8'hBD, 8'hF0, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0);
      decode_at(16'h0440, 1'b0, 8'hB9, 8'h80, 8'h12, 8'h00, 8'hFF, 8'h00, 1'b0);
      // Pre-indexed pointer at the end of page zero wraps to location zero.
      decode_at(16'h0450, 1'b0, 8'hA1, 8'hFE, 8'h00, 8'h01, 8'h00, 8'h00, 1'b0);
      decode_at(16'h0460, 1'b0, 8'hB1, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0);
      // Indirect jump through a pointer on a page boundary carries into the high byte.
      decode_at(16'h0470, 1'b0, odea_pkg::OPC_JMP + 8'h20, 8'hFF, 8'h06, 8'h00, 8'h00, 8'h00,
                1'b0);
      decode_at(16'h0480, 1'b0, odea_pkg::OPC_JMP, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 1'b1);
      decode_at(16'h0490, 1'b0, odea_pkg::OPC_JSR, 8'hCD, 8'hAB, 8'h00, 8'h00, 8'h00, 1'b0);
      decode_at(16'h04A0, 1'b0, 8'hEA, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1);
      // Illegal opcode and a branch request on a non-branch opcode.
      decode_at(16'h04B0, 1'b0, 8'hFF, 8'h10, 8'h20, 8'h05, 8'h00, 8'hFF, 1'b1);
      decode_at(16'h04C0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1);
      decode_at(16'h0000, 1'b0, 8'h85, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      wait_for_results();
   endtask

   task automatic test_random_programs();
      logic [15:0] pc;
      int choice;
      bit paused = 1'b0;
      while (beats_sent < 1300) begin
         choice = $urandom_range(0, 99);
         case ($urandom_range(0, 4))
            0: pc = $urandom_range(0, 16'h00FF);
            1: pc = $urandom_range(16'hFF00, 16'hFFFF);
            2: pc = $urandom_range(16'h0200, 16'h02FF);
            default: pc = $urandom;
         endcase
         if (choice < 10) begin
            write_byte($urandom, $urandom);
         end else if (choice < 25) begin
            decode_at(pc, 1'b1, 8'h00, 8'h00, 8'h00, $urandom, $urandom, $urandom, $urandom);
         end else begin
            decode_at(pc, 1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom);
         end
         // Let everything drain once, midway through.
         if (!paused && beats_sent > 700) begin
            paused = 1'b1;
            wait_for_results();
         end
      end
      wait_for_results();
   endtask

   initial begin
      int modes;
      modes = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;
      test_addressing_modes();
      test_random_programs();
      foreach (mode_seen[m]) modes += mode_seen[m];
      $display("Checked %0d write beats and %0d decode beats, %0d addressing modes seen.",
               writes_checked, decodes_checked, modes);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d results missing.", mismatches, pending_results.size());
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Timed out with %0d results outstanding.", pending_results.size());
      $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire
